>>> hw/rtl/kvt_pkg.sv
// Shared types and constants for the key-value text tokenizer.
// No dependencies; every other file takes its names from here by scope.
package kvt_pkg;

	// Default bound on dictionary nesting
	localparam int MAX_DEPTH_DEF = 64;

	// Bound on reprocessing passes for one byte
	localparam int PASSES = 6;

	// Slots for the events that one byte can cause
	localparam int MAX_EVENTS = 4;

	// Byte codes that steer the parse
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	typedef enum logic [2:0] {
		MODE_SKIP_KEY   = 3'd0,
		MODE_STRING     = 3'd1,
		MODE_ESCAPE     = 3'd2,
		MODE_SKIP_VALUE = 3'd3,
		MODE_DONE       = 3'd4,
		MODE_ERROR      = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		EV_CONTENT = 3'd0,
		EV_STR_END = 3'd1,
		EV_OPEN    = 3'd2,
		EV_CLOSE   = 3'd3,
		EV_DONE    = 3'd4,
		EV_ERROR   = 3'd5
	} kind_t;

	// Parser control state (depth travels beside it, its width is a parameter)
	typedef struct packed {
		mode_t mode;
		logic  is_key;
		logic  quoted;
	} ctl_t;

	localparam ctl_t CTL_RESET = '{mode: MODE_SKIP_KEY, is_key: 1'b1, quoted: 1'b0};

	// One event as held in the result stage
	typedef struct packed {
		kind_t      kind;
		logic [7:0] content;
		logic       is_key;
		logic [6:0] depth;
	} evt_t;

	// Input item
	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_document;
	} txt_t;

	// Result item
	typedef struct packed {
		kind_t      event_kind;
		logic [7:0] content_byte;
		logic       is_key;
		logic [6:0] nest_depth;
		logic       last_of_run;
	} tok_t;

endpackage

>>> hw/rtl/kvt_decode.sv
// Per-byte decode for the key-value tokenizer: next state and up to four events.
// Purely combinational; uses kvt_pkg types and byte codes.
module kvt_decode #(
	parameter int MAX_DEPTH = kvt_pkg::MAX_DEPTH_DEF,
	parameter int DW        = $clog2(MAX_DEPTH + 1)
) (
	input  kvt_pkg::ctl_t  ctl,
	input  logic [DW-1:0]  depth,
	input  logic [7:0]     text_byte,
	input  logic           end_of_document,
	output kvt_pkg::ctl_t  ctl_next,
	output logic [DW-1:0]  depth_next,
	output kvt_pkg::evt_t  evs [kvt_pkg::MAX_EVENTS],
	output logic [2:0]     n_evs
);

	localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);

	// Low seven bits of the depth, zero-extended when the counter is narrower
	function automatic logic [6:0] lo7(input logic [DW-1:0] d);
		logic [DW+6:0] x;
		x = {7'd0, d};
		return x[6:0];
	endfunction

	function automatic kvt_pkg::evt_t mk(input kvt_pkg::kind_t k, input logic [7:0] c,
			input logic key, input logic [DW-1:0] d);
		kvt_pkg::evt_t e;
		e.kind    = k;
		e.content = c;
		e.is_key  = key;
		e.depth   = lo7(d);
		return e;
	endfunction

	logic blank;
	logic brace;

	assign blank = (text_byte == kvt_pkg::CH_SPACE) ||
		((text_byte >= kvt_pkg::CH_TAB) && (text_byte <= kvt_pkg::CH_CR));
	assign brace = (text_byte == kvt_pkg::CH_LBRACE) || (text_byte == kvt_pkg::CH_RBRACE);

	// Run the reprocessing passes, each adding at most two events
	always_comb begin
		kvt_pkg::ctl_t c;
		logic [DW-1:0] d;
		logic          again;
		logic          r0;
		logic          r1;
		kvt_pkg::evt_t e0;
		kvt_pkg::evt_t e1;
		logic [2:0]    n;

		c     = ctl;
		d     = depth;
		again = 1'b1;
		n     = 3'd0;
		for (int i = 0; i < kvt_pkg::MAX_EVENTS; i++) begin
			evs[i] = '0;
		end

		for (int p = 0; p < kvt_pkg::PASSES; p++) begin
			r0 = 1'b0;
			r1 = 1'b0;
			e0 = '0;
			e1 = '0;
			if (again) begin
				again = 1'b0;
				unique case (c.mode)
					kvt_pkg::MODE_SKIP_KEY: begin
						if (!blank) begin
							if ((d != '0) && (text_byte == kvt_pkg::CH_RBRACE)) begin
								d  = d - DW'(1);
								r0 = 1'b1;
								e0 = mk(kvt_pkg::EV_CLOSE, 8'd0, 1'b0, d);
								if (d == '0) begin
									r1     = 1'b1;
									e1     = mk(kvt_pkg::EV_DONE, 8'd0, 1'b0, d);
									c.mode = kvt_pkg::MODE_DONE;
								end
							end else begin
								c.is_key = 1'b1;
								c.mode   = kvt_pkg::MODE_STRING;
								c.quoted = (text_byte == kvt_pkg::CH_QUOTE);
								again    = !c.quoted;
							end
						end
					end
					kvt_pkg::MODE_SKIP_VALUE: begin
						if (!blank) begin
							if (text_byte == kvt_pkg::CH_LBRACE) begin
								if (d >= DEPTH_MAX) begin
									r0     = 1'b1;
									e0     = mk(kvt_pkg::EV_ERROR, 8'd0, 1'b0, d);
									c.mode = kvt_pkg::MODE_ERROR;
								end else begin
									d      = d + DW'(1);
									r0     = 1'b1;
									e0     = mk(kvt_pkg::EV_OPEN, 8'd0, 1'b0, d);
									c.mode = kvt_pkg::MODE_SKIP_KEY;
								end
							end else begin
								c.is_key = 1'b0;
								c.mode   = kvt_pkg::MODE_STRING;
								c.quoted = (text_byte == kvt_pkg::CH_QUOTE);
								again    = !c.quoted;
							end
						end
					end
					kvt_pkg::MODE_STRING: begin
						if (text_byte == kvt_pkg::CH_BSLASH) begin
							r0     = 1'b1;
							e0     = mk(kvt_pkg::EV_CONTENT, text_byte, c.is_key, d);
							c.mode = kvt_pkg::MODE_ESCAPE;
						end else if (c.quoted ? (text_byte == kvt_pkg::CH_QUOTE)
								: (blank || brace)) begin
							// String end: go on to its value, or close out the value
							r0 = 1'b1;
							e0 = mk(kvt_pkg::EV_STR_END, 8'd0, c.is_key, d);
							if (c.is_key) begin
								c.mode = kvt_pkg::MODE_SKIP_VALUE;
							end else if (d == '0) begin
								r1     = 1'b1;
								e1     = mk(kvt_pkg::EV_DONE, 8'd0, 1'b0, d);
								c.mode = kvt_pkg::MODE_DONE;
							end else begin
								c.mode = kvt_pkg::MODE_SKIP_KEY;
							end
							// A brace that ends an unquoted string is seen again
							again = !c.quoted && brace;
						end else begin
							r0 = 1'b1;
							e0 = mk(kvt_pkg::EV_CONTENT, text_byte, c.is_key, d);
						end
					end
					kvt_pkg::MODE_ESCAPE: begin
						r0     = 1'b1;
						e0     = mk(kvt_pkg::EV_CONTENT, text_byte, c.is_key, d);
						c.mode = kvt_pkg::MODE_STRING;
					end
					kvt_pkg::MODE_DONE, kvt_pkg::MODE_ERROR: begin
						again = 1'b0;
					end
					default: begin
						again = 1'b0;
					end
				endcase
			end
			// Append this pass's events, dropping any beyond the last slot
			if (r0 && (n < 3'd4)) begin
				evs[n[1:0]] = e0;
				n           = n + 3'd1;
			end
			if (r1 && (n < 3'd4)) begin
				evs[n[1:0]] = e1;
				n           = n + 3'd1;
			end
		end

		// Final byte: flag an unfinished parse, then return to reset
		if (end_of_document) begin
			if ((c.mode != kvt_pkg::MODE_DONE) && (c.mode != kvt_pkg::MODE_ERROR) &&
					(n < 3'd4)) begin
				evs[n[1:0]] = mk(kvt_pkg::EV_ERROR, 8'd0, 1'b0, d);
				n           = n + 3'd1;
			end
			c = kvt_pkg::CTL_RESET;
			d = '0;
		end

		ctl_next   = c;
		depth_next = d;
		n_evs      = n;
	end

endmodule

>>> hw/rtl/kvt_event_buf.sv
// Result stage of the tokenizer: holds the events of one byte and hands them out in order.
// Uses kvt_pkg event and result types.
module kvt_event_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  kvt_pkg::evt_t evs [kvt_pkg::MAX_EVENTS],
	input  logic [2:0]    n_evs,
	output logic          free,
	output logic          tok_valid,
	input  logic          tok_ready,
	output kvt_pkg::tok_t tok
);

	kvt_pkg::evt_t ev_q [kvt_pkg::MAX_EVENTS];
	logic          valid_q;
	logic [1:0]    idx_q;
	logic [1:0]    last_idx_q;
	logic [2:0]    n_m1;
	logic          at_last;
	logic          xfer;

	assign n_m1    = n_evs - 3'd1;
	assign at_last = (idx_q == last_idx_q);
	assign xfer    = valid_q && tok_ready;
	assign free    = !valid_q || (tok_ready && at_last);

	// Control: load a new bundle, or step through the current one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			idx_q      <= 2'd0;
			last_idx_q <= 2'd0;
		end else if (load) begin
			valid_q    <= 1'b1;
			idx_q      <= 2'd0;
			last_idx_q <= n_m1[1:0];
		end else if (xfer) begin
			if (at_last) begin
				valid_q <= 1'b0;
				idx_q   <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// Payload: capture the bundle on load
	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < kvt_pkg::MAX_EVENTS; i++) begin
				ev_q[i] <= evs[i];
			end
		end
	end

	assign tok_valid        = valid_q;
	assign tok.event_kind   = ev_q[idx_q].kind;
	assign tok.content_byte = ev_q[idx_q].content;
	assign tok.is_key       = ev_q[idx_q].is_key;
	assign tok.nest_depth   = ev_q[idx_q].depth;
	assign tok.last_of_run  = at_last;

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (idx_q <= last_idx_q))
		else $error("event index past end of bundle");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (free && (n_evs != 3'd0) && (n_evs <= 3'd4)))
		else $error("bundle loaded while busy or with bad count");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && at_last && !load) |=> !valid_q)
		else $error("stage still valid after final transfer");

	a_step_index: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && !at_last && !load) |=> (valid_q && (idx_q == $past(idx_q) + 2'd1)))
		else $error("index did not advance on transfer");

endmodule

>>> hw/rtl/keyvalue_text_tokenizer.sv
// Top level of the key-value text tokenizer: input register, parser state, result stage.
// Depends on kvt_pkg, kvt_decode and kvt_event_buf.
//
// Takes a key-value text document one byte per transfer on the txt channel and
// gives a stream of events on the tok channel: content bytes of keys and values,
// string ends, dict open and close, done and error, each with the nesting depth
// after it and a mark on the last event of its byte. A byte is held in the
// input register, where it is decoded against the parser state in the same cycle;
// its events (none to four) then wait in the result stage. The block takes one byte
// per cycle as long as each byte gives at most one event and tok_ready is high; a byte
// that gives k events holds the result stage for k output transfers, and bytes that
// give none pass without waiting on it. The end_of_document byte returns the parser
// to its reset state.
module keyvalue_text_tokenizer #(
	parameter int MAX_DEPTH = kvt_pkg::MAX_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          txt_valid,
	output logic          txt_ready,
	input  kvt_pkg::txt_t txt,
	output logic          tok_valid,
	input  logic          tok_ready,
	output kvt_pkg::tok_t tok
);

	localparam int DW = $clog2(MAX_DEPTH + 1);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          eod_s1;
	kvt_pkg::ctl_t ctl_q;
	logic [DW-1:0] depth_q;

	kvt_pkg::ctl_t ctl_next;
	logic [DW-1:0] depth_next;
	kvt_pkg::evt_t evs [kvt_pkg::MAX_EVENTS];
	logic [2:0]    n_evs;
	logic          buf_free;
	logic          take_s1;
	logic          load;

	// Consume the registered byte when its events fit, or when it has none
	assign take_s1   = valid_s1 && ((n_evs == 3'd0) || buf_free);
	assign load      = take_s1 && (n_evs != 3'd0);
	assign txt_ready = !valid_s1 || take_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (txt_ready) begin
			valid_s1 <= txt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (txt_ready && txt_valid) begin
			byte_s1 <= txt.text_byte;
			eod_s1  <= txt.end_of_document;
		end
	end

	// Parser state: advance once per consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q   <= kvt_pkg::CTL_RESET;
			depth_q <= '0;
		end else if (take_s1) begin
			ctl_q   <= ctl_next;
			depth_q <= depth_next;
		end
	end

	kvt_decode #(
		.MAX_DEPTH (MAX_DEPTH),
		.DW        (DW)
	) u_decode (
		.ctl             (ctl_q),
		.depth           (depth_q),
		.text_byte       (byte_s1),
		.end_of_document (eod_s1),
		.ctl_next        (ctl_next),
		.depth_next      (depth_next),
		.evs             (evs),
		.n_evs           (n_evs)
	);

	kvt_event_buf u_event_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.evs       (evs),
		.n_evs     (n_evs),
		.free      (buf_free),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok       (tok)
	);

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(MAX_DEPTH))
		else $error("nesting depth beyond bound");

	a_eod_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(take_s1 && eod_s1) |=> ((ctl_q == kvt_pkg::CTL_RESET) && (depth_q == '0)))
		else $error("state not back at reset after final byte");

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!take_s1 |=> ($stable(ctl_q) && $stable(depth_q)))
		else $error("state moved without a consumed byte");

endmodule
